FILE: rtl/efe_pkg.sv
package efe_pkg;

  localparam logic [7:0] FLAG_RESET     = 8'h7E;
  localparam logic [7:0] ESCAPE_RESET   = 8'h7D;
  localparam logic [7:0] ESC_CODE_FLAG  = 8'h02;
  localparam logic [7:0] ESC_CODE_ESC   = 8'h01;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic REG_FLAG   = 1'b0;
  localparam logic REG_ESCAPE = 1'b1;

  localparam logic [1:0] CLS_PLAIN = 2'd0;
  localparam logic [1:0] CLS_FLAG  = 2'd1;
  localparam logic [1:0] CLS_ESC   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_done;
  } out_item_t;

  typedef struct packed {
    logic       open;
    logic [7:0] data;
    logic [1:0] data_cls;
    logic       last;
    logic [7:0] chk;
    logic [1:0] chk_cls;
  } job_t;

endpackage

FILE: rtl/efe_front.sv
module efe_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  efe_pkg::in_item_t in_item,
  input  logic [7:0]      flag_value,
  input  logic [7:0]      escape_value,
  input  logic            q_full,
  output logic            q_push,
  output efe_pkg::job_t   q_job
);
  import efe_pkg::*;

  logic       inside_frame_r, inside_frame_nxt;
  logic [7:0] check_r, check_nxt;
  logic [7:0] chk_new;

  function automatic logic [1:0] classify(input logic [7:0] v, input logic [7:0] f,
                                          input logic [7:0] e);
    logic [1:0] c;
    if (v == f) begin
      c = CLS_FLAG;
    end else if (v == e) begin
      c = CLS_ESC;
    end else begin
      c = CLS_PLAIN;
    end
    return c;
  endfunction

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign chk_new  = (inside_frame_r ? check_r : 8'h00) ^ in_item.data_byte;

  always_comb begin
    q_job.open     = !inside_frame_r;
    q_job.data     = in_item.data_byte;
    q_job.data_cls = classify(in_item.data_byte, flag_value, escape_value);
    q_job.last     = in_item.last_byte;
    q_job.chk      = chk_new;
    q_job.chk_cls  = classify(chk_new, flag_value, escape_value);
  end

  always_comb begin
    inside_frame_nxt = inside_frame_r;
    check_nxt        = check_r;
    if (q_push) begin
      inside_frame_nxt = !in_item.last_byte;
      check_nxt        = in_item.last_byte ? 8'h00 : chk_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_frame_r <= 1'b0;
      check_r        <= 8'h00;
    end else begin
      inside_frame_r <= inside_frame_nxt;
      check_r        <= check_nxt;
    end
  end

endmodule

FILE: rtl/efe_queue.sv
module efe_queue #(
  parameter int Depth = efe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  efe_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output efe_pkg::job_t head_job
);
  import efe_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

  job_t          mem_r [Depth];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/efe_back.sv
module efe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        flag_value,
  input  logic [7:0]        escape_value,
  input  logic              q_not_empty,
  input  efe_pkg::job_t     q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output efe_pkg::out_item_t out_item
);
  import efe_pkg::*;

  localparam logic [2:0] ST_OPEN  = 3'd0;
  localparam logic [2:0] ST_DATA  = 3'd1;
  localparam logic [2:0] ST_DESC  = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_CESC  = 3'd4;
  localparam logic [2:0] ST_CLOSE = 3'd5;

  logic       busy_r, busy_nxt;
  job_t       job_r, job_nxt;
  logic [2:0] step_r, step_nxt;
  logic [2:0] step_follow;
  logic       fin;
  logic       out_take;

  always_comb begin
    step_follow = ST_CLOSE;
    fin         = 1'b0;
    out_item.out_byte = flag_value;
    unique case (step_r)
      ST_OPEN: begin
        step_follow       = ST_DATA;
        out_item.out_byte = flag_value;
      end
      ST_DATA: begin
        if (job_r.data_cls != CLS_PLAIN) begin
          step_follow = ST_DESC;
        end else if (job_r.last) begin
          step_follow = ST_CHK;
        end else begin
          fin = 1'b1;
        end
        out_item.out_byte = (job_r.data_cls == CLS_PLAIN) ? job_r.data : escape_value;
      end
      ST_DESC: begin
        if (job_r.last) begin
          step_follow = ST_CHK;
        end else begin
          fin = 1'b1;
        end
        out_item.out_byte = (job_r.data_cls == CLS_FLAG) ? ESC_CODE_FLAG : ESC_CODE_ESC;
      end
      ST_CHK: begin
        step_follow       = (job_r.chk_cls != CLS_PLAIN) ? ST_CESC : ST_CLOSE;
        out_item.out_byte = (job_r.chk_cls == CLS_PLAIN) ? job_r.chk : escape_value;
      end
      ST_CESC: begin
        step_follow       = ST_CLOSE;
        out_item.out_byte = (job_r.chk_cls == CLS_FLAG) ? ESC_CODE_FLAG : ESC_CODE_ESC;
      end
      ST_CLOSE: begin
        fin               = 1'b1;
        out_item.out_byte = flag_value;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
    out_item.last_of_run = fin;
    out_item.frame_done  = (step_r == ST_CLOSE);
  end

  assign out_valid = busy_r;
  assign out_take  = busy_r && !out_stall;
  assign q_pop     = q_not_empty && (!busy_r || (out_take && fin));

  always_comb begin
    busy_nxt = busy_r;
    job_nxt  = job_r;
    step_nxt = step_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      job_nxt  = q_head;
      step_nxt = q_head.open ? ST_OPEN : ST_DATA;
    end else if (out_take) begin
      if (fin) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_follow;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= ST_OPEN;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

FILE: rtl/escaped_frame_encoder_xor_check.sv
// Channel   Ports                             Direction  Payload
// input     in_valid, in_stall, in_item       in         data_byte, last_byte
// result    out_valid, out_stall, out_item    out        out_byte, last_of_run, frame_done
// config    cfg_wr_en, cfg_index, cfg_data    in         flag_value, escape_value
//
// Each item gives one to six result items, one per clock while out_stall is low; a plain
// byte inside a frame gives a single result item, so the result port sets the rate.
// A queue of QueueDepth jobs lets the input side run ahead of the output sequencer.
// rst_n is synchronous; it closes any open frame and restores the default flag and escape.
// The input stalls only when the queue is full.
module escaped_frame_encoder_xor_check #(
  parameter int QueueDepth = efe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  efe_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output efe_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);
  import efe_pkg::*;

  logic [7:0] flag_r, flag_nxt;
  logic [7:0] escape_r, escape_nxt;
  logic       q_push, q_pop, q_full, q_not_empty;
  job_t       push_job, head_job;

  always_comb begin
    flag_nxt   = flag_r;
    escape_nxt = escape_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_FLAG:   flag_nxt   = cfg_data;
        REG_ESCAPE: escape_nxt = cfg_data;
        default:    flag_nxt   = flag_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r   <= FLAG_RESET;
      escape_r <= ESCAPE_RESET;
    end else begin
      flag_r   <= flag_nxt;
      escape_r <= escape_nxt;
    end
  end

  efe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .flag_value   (flag_r),
    .escape_value (escape_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  efe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  efe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .flag_value   (flag_r),
    .escape_value (escape_r),
    .q_not_empty  (q_not_empty),
    .q_head       (head_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

endmodule

FILE: bench/escaped_frame_encoder_xor_check_test.sv
`timescale 1ns / 100ps

module escaped_frame_encoder_xor_check_test;
  import efe_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_index = REG_FLAG;
  logic [7:0] cfg_data = 8'h00;

  in_item_t   raw_bytes_q[$];
  out_item_t  wire_expected[$];
  logic [8:0] frame_run[$];

  logic [7:0] cur_flag = FLAG_RESET;
  logic [7:0] cur_escape = ESCAPE_RESET;
  logic       frame_open = 1'b0;
  logic [7:0] xor_sum = 8'h00;

  int  bytes_queued = 0;
  int  bytes_taken = 0;
  int  mismatches = 0;
  int  cycles = 0;
  int  in_gap = 0;
  int  in_calm = 0;
  int  stall_left = 0;
  int  flow_left = 0;
  logic in_done = 1'b0;

  escaped_frame_encoder_xor_check i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void emit_escaped(logic [7:0] b);
    if (b == cur_flag) begin
      frame_run.push_back({cur_escape, 1'b0});
      frame_run.push_back({ESC_CODE_FLAG, 1'b0});
    end else if (b == cur_escape) begin
      frame_run.push_back({cur_escape, 1'b0});
      frame_run.push_back({ESC_CODE_ESC, 1'b0});
    end else begin
      frame_run.push_back({b, 1'b0});
    end
  endfunction

  function automatic void encode_content_byte(in_item_t it);
    logic [8:0] nb;
    out_item_t  exp_item;
    if (!frame_open) begin
      frame_run.push_back({cur_flag, 1'b0});
      frame_open = 1'b1;
      xor_sum = 8'h00;
    end
    xor_sum = xor_sum ^ it.data_byte;
    emit_escaped(it.data_byte);
    if (it.last_byte) begin
      emit_escaped(xor_sum);
      frame_run.push_back({cur_flag, 1'b1});
      frame_open = 1'b0;
      xor_sum = 8'h00;
    end
    while (frame_run.size() > 0) begin
      nb = frame_run.pop_front();
      exp_item.out_byte = nb[8:1];
      exp_item.frame_done = nb[0];
      exp_item.last_of_run = (frame_run.size() == 0);
      wire_expected.push_back(exp_item);
    end
  endfunction

  function automatic int pick_in_gap();
    int r;
    if (in_calm > 0) begin
      in_calm = in_calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(6, 20);
    in_calm = $urandom_range(20, 50);
    return 0;
  endfunction

  function automatic logic [7:0] pick_content(logic [7:0] fl, logic [7:0] es);
    int         r;
    logic [7:0] v;
    r = $urandom_range(0, 99);
    v = 8'($urandom_range(0, 255));
    if (r < 20) v = fl;
    else if (r < 35) v = es;
    else if (r < 40) v = 8'h00;
    else if (r < 45) v = 8'hFF;
    return v;
  endfunction

  task automatic push_item(logic [7:0] data, logic last);
    in_item_t it;
    it.data_byte = data;
    it.last_byte = last;
    raw_bytes_q.push_back(it);
    bytes_queued = bytes_queued + 1;
  endtask

  task automatic send_frame(int len, logic [7:0] fl, logic [7:0] es, logic close);
    for (int i = 0; i < len; i++) begin
      push_item(pick_content(fl, es), close && (i == len - 1));
    end
  endtask

  task automatic wait_drain();
    while (bytes_taken != bytes_queued || wire_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_FLAG) begin
      cur_flag = value;
    end else begin
      cur_escape = value;
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_done) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (raw_bytes_q.size() > 0) begin
        in_item <= raw_bytes_q.pop_front();
        in_valid <= 1'b1;
        in_gap = pick_in_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (flow_left > 0) begin
      flow_left = flow_left - 1;
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) flow_left = $urandom_range(1, 8);
      else if (r < 85) stall_left = $urandom_range(1, 3);
      else if (r < 95) stall_left = $urandom_range(6, 25);
      else flow_left = $urandom_range(30, 80);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    in_done <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        encode_content_byte(in_item);
        bytes_taken = bytes_taken + 1;
      end
      if (out_valid && !out_stall) begin
        if (wire_expected.size() == 0) begin
          $error("unexpected result item: out_byte %h", out_item.out_byte);
          mismatches = mismatches + 1;
        end else begin
          want = wire_expected.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, out_item.out_byte);
            mismatches = mismatches + 1;
          end
          if (out_item.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", want.last_of_run,
                   out_item.last_of_run);
            mismatches = mismatches + 1;
          end
          if (out_item.frame_done !== want.frame_done) begin
            $error("frame_done: expected %b, actual %b", want.frame_done,
                   out_item.frame_done);
            mismatches = mismatches + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** escaped_frame_encoder_xor_check: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [7:0] phase_flag[0:7];
    logic [7:0] phase_escape[0:7];
    int         target;
    int         len;
    int         r;

    phase_flag[0] = 8'h00;  phase_escape[0] = 8'hFF;
    phase_flag[1] = 8'hFF;  phase_escape[1] = 8'h00;
    phase_flag[2] = 8'h55;  phase_escape[2] = 8'h55;
    phase_flag[3] = 8'h00;  phase_escape[3] = 8'h00;
    phase_flag[4] = 8'hFF;  phase_escape[4] = 8'hFF;
    phase_flag[5] = FLAG_RESET;  phase_escape[5] = ESCAPE_RESET;
    phase_flag[6] = 8'($urandom_range(0, 255));  phase_escape[6] = 8'($urandom_range(0, 255));
    phase_flag[7] = 8'($urandom_range(0, 255));  phase_escape[7] = 8'($urandom_range(0, 255));

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Single-byte messages, including the flag and escape values themselves.
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b1);
    push_item(FLAG_RESET, 1'b1);
    push_item(ESCAPE_RESET, 1'b1);
    push_item(ESC_CODE_FLAG, 1'b1);
    // A frame with both special bytes inside it.
    push_item(FLAG_RESET, 1'b0);
    push_item(ESCAPE_RESET, 1'b0);
    push_item(8'h55, 1'b0);
    push_item(8'hAA, 1'b0);
    push_item(ESC_CODE_ESC, 1'b1);
    // Frames whose check byte equals the escape and then the flag value.
    push_item(8'h10, 1'b0);
    push_item(8'h6D, 1'b1);
    push_item(8'h7F, 1'b0);
    push_item(8'h01, 1'b1);
    wait_drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_FLAG, phase_flag[p]);
      write_reg(REG_ESCAPE, phase_escape[p]);
      target = bytes_queued + 45;
      while (bytes_queued < target) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 6);
        else if (r < 95) len = $urandom_range(7, 16);
        else len = $urandom_range(17, 40);
        send_frame(len, phase_flag[p], phase_escape[p], 1'b1);
        if ($urandom_range(0, 11) == 0) begin
          wait_drain();
        end else begin
          @(negedge clk);
        end
      end
      // Odd phases leave a frame open so the next register setting applies mid-frame.
      if (p % 2 == 1) begin
        send_frame($urandom_range(1, 4), phase_flag[p], phase_escape[p], 1'b0);
      end
      wait_drain();
    end

    send_frame(3, cur_flag, cur_escape, 1'b1);
    wait_drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && wire_expected.size() == 0) begin
      $display("** escaped_frame_encoder_xor_check: PASSED **");
    end else begin
      $display("** escaped_frame_encoder_xor_check: FAILED **");
    end
    $finish;
  end

endmodule
